[design/vtsi_pkg.sv]
// Shared types and constants for the velocity timestamp sync interpolator.
package vtsi_pkg;
  localparam int TIME_W = 48;
  localparam int VEL_W = 32;
  localparam int GAP_W = 24;
  localparam int LANES = 6;
  localparam logic [GAP_W-1:0] GAP_RESET = 24'd200000;
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_SYNC = 1'b1;
  localparam logic [0:0] REG_MAX_GAP = 1'b0;

  typedef logic signed [VEL_W-1:0] vel_t;
  typedef vel_t [LANES-1:0] vel_vec_t;
endpackage

[design/vtsi_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module vtsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[design/vtsi_div.sv]
// Restoring divider for the interpolation weight, one quotient bit per cycle.
module vtsi_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CW = $clog2(NUM_W + 1);
  logic [NUM_W-1:0] q;
  logic [DEN_W:0] rem;
  logic [DEN_W-1:0] d;
  logic [CW-1:0] cnt;
  logic run;
  logic [DEN_W:0] trial;

  assign trial = {rem[DEN_W-1:0], q[NUM_W-1]};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        q <= num;
        rem <= '0;
        d <= den;
        cnt <= CW'(NUM_W);
      end else if (run) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q <= {q[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[design/vtsi_lane.sv]
// One interpolation lane: blends two samples of one velocity component.
module vtsi_lane import vtsi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               start,
  input  vel_t               v0,
  input  vel_t               v1,
  input  logic [FRAC_BITS:0] w,
  output vel_t               res
);
  localparam int PW = VEL_W + FRAC_BITS + 2;
  logic signed [PW-1:0] p0, p1;
  logic signed [PW:0] s;
  logic [FRAC_BITS:0] wi;

  assign wi = (FRAC_BITS+1)'(1) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (start) begin
      p0 <= PW'(v0) * PW'($signed({1'b0, wi - w}));
      p1 <= PW'(v1) * PW'($signed({1'b0, w}));
    end
  end

  assign s = (PW+1)'(p0) + (PW+1)'(p1) + (PW+1)'(1 << (FRAC_BITS - 1));
  assign res = VEL_W'(s >>> FRAC_BITS);
endmodule

[design/velocity_timestamp_sync_interpolator.sv]
// Top level: sample queue, sync sequencer, divider and six blending lanes.
// Usage:
//   s_axis carries requests: tuser = func (0 push, 1 sync), tdata from bit 0 =
//   item_time[47:0], ang_vel_x/y/z, lin_vel_x/y/z (32 bits each).
//   m_axis carries one result per sync: tuser = sync_ok, tdata from bit 0 =
//   out_time, out_ang_x/y/z, out_lin_x/y/z. Pushes give no result.
//   APB register 0 (address 0) is max_gap_us, 24 bits, reset 200000.
// Sequence:
//   A push writes the queue and returns to idle. A sync drops each stale
//   sample, reads the queue and checks the gap, runs the restoring divider
//   (load, 48+FRAC_BITS weight bits at one per cycle, done), then the lane
//   multipliers, and loads the output register. The divider sets the rate; a
//   failed check or equal neighbour times skip it. One request is in flight
//   at a time; a new one is taken once the result sits in the output register,
//   even while stalled.
// Reset:
//   rst (synchronous) empties the queue and restores max_gap_us. Queue RAM
//   contents are not cleared; only entries below the count are read.
//   A stalled output holds its result and blocks the next sync result.
module velocity_timestamp_sync_interpolator import vtsi_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [239:0] s_axis_tdata,   // item_time, ang x/y/z, lin x/y/z
  input  logic         s_axis_tuser,   // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [239:0] m_axis_tdata,   // out_time, ang x/y/z, lin x/y/z
  output logic         m_axis_tuser,   // sync_ok
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = TIME_W + FRAC_BITS;
  localparam int VW = VEL_W * LANES;

  typedef enum logic [3:0] {
    IDLE, RD0, RD1, CHK, GAP, DIV, MUL, BLEND, OUTW
  } state_t;

  state_t state;
  logic [GAP_W-1:0] max_gap;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [TIME_W-1:0] t_req, t0, t1;
  logic func_q;
  logic sync_ok;
  logic [VW-1:0] vin_q;

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr == {REG_MAX_GAP, 1'b0}) ? {8'd0, max_gap} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) max_gap <= GAP_RESET;
    else if (psel && penable && pwrite && paddr == {REG_MAX_GAP, 1'b0})
      max_gap <= pwdata[GAP_W-1:0];
  end

  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] h, logic [CW-1:0] k);
    logic [CW:0] i;
    i = (CW+1)'(h) + (CW+1)'(k);
    if (i >= (CW+1)'(QUEUE_DEPTH)) i = i - (CW+1)'(QUEUE_DEPTH);
    return AW'(i);
  endfunction

  // memories
  logic t_we, v_we;
  logic [AW-1:0] t_waddr, t_raddr, v_raddr0, v_raddr1;
  logic [TIME_W-1:0] t_rdata;
  logic [VW-1:0] v0_rdata, v1_rdata;

  vtsi_ram #(.WIDTH(TIME_W), .DEPTH(QUEUE_DEPTH)) u_tram (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_req), .raddr(t_raddr), .rdata(t_rdata));
  vtsi_ram #(.WIDTH(VW), .DEPTH(QUEUE_DEPTH)) u_vram0 (
    .clk, .we(v_we), .waddr(t_waddr), .wdata(vin_q), .raddr(v_raddr0), .rdata(v0_rdata));
  vtsi_ram #(.WIDTH(VW), .DEPTH(QUEUE_DEPTH)) u_vram1 (
    .clk, .we(v_we), .waddr(t_waddr), .wdata(vin_q), .raddr(v_raddr1), .rdata(v1_rdata));

  logic push_full;
  assign push_full = (count == CW'(QUEUE_DEPTH));
  assign t_we = (state == RD0) && (func_q == FUNC_PUSH);
  assign v_we = t_we;
  assign t_waddr = push_full ? head : slot_of(head, count);
  assign v_raddr0 = head;
  assign v_raddr1 = slot_of(head, CW'(1));

  // divider and lanes
  logic div_start, div_done;
  logic [NW-1:0] quo;
  logic [TIME_W-1:0] d0, d1, span;
  logic [FRAC_BITS:0] w;
  logic [FRAC_BITS:0] one_w;
  vel_vec_t lane_res;

  assign one_w = (FRAC_BITS+1)'(1) << FRAC_BITS;
  assign d0 = t_req - t0;
  assign d1 = t1 - t_req;
  assign span = t1 - t0;

  vtsi_div #(.NUM_W(NW), .DEN_W(TIME_W)) u_div (
    .clk, .rst, .start(div_start), .num({d0, {FRAC_BITS{1'b0}}}), .den(span),
    .done(div_done), .quo(quo));

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    vtsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk, .start(state == MUL),
      .v0(v0_rdata[g*VEL_W +: VEL_W]), .v1(v1_rdata[g*VEL_W +: VEL_W]),
      .w(w), .res(lane_res[g]));
  end

  logic need_two;
  assign need_two = (count >= CW'(2));
  assign s_axis_tready = (state == IDLE);

  always_comb begin
    t_raddr = head;
    if (state == RD1 || state == CHK) t_raddr = slot_of(head, CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      head <= '0;
      count <= '0;
      m_axis_tvalid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (m_axis_tready && state != OUTW) m_axis_tvalid <= 1'b0;
      case (state)
        IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            func_q <= s_axis_tuser;
            t_req <= s_axis_tdata[TIME_W-1:0];
            vin_q <= s_axis_tdata[TIME_W +: VW];
            state <= RD0;
          end
        end
        RD0: begin
          if (func_q == FUNC_PUSH) begin
            if (push_full) head <= slot_of(head, CW'(1));
            else count <= count + 1'b1;
            state <= IDLE;
          end else if (!need_two) begin
            state <= OUTW;
            w <= '0;
            sync_ok <= 1'b0;
          end else state <= RD1;
        end
        RD1: begin
          t0 <= t_rdata;
          state <= CHK;
        end
        CHK: begin
          if (t0 > t_req) begin
            sync_ok <= 1'b0;
            state <= OUTW;
          end else if (t_rdata < t_req) begin
            head <= slot_of(head, CW'(1));
            count <= count - 1'b1;
            state <= RD0;
          end else begin
            t1 <= t_rdata;
            state <= GAP;
          end
        end
        GAP: begin
          if (d0 > TIME_W'(max_gap) || d1 > TIME_W'(max_gap)) begin
            sync_ok <= 1'b0;
            state <= OUTW;
          end else if (span == '0) begin
            w <= '0;
            state <= MUL;
          end else begin
            div_start <= 1'b1;
            state <= DIV;
          end
        end
        DIV: begin
          if (div_done) begin
            w <= (quo > NW'(one_w)) ? one_w : quo[FRAC_BITS:0];
            state <= MUL;
          end
        end
        MUL: state <= BLEND;
        BLEND: begin
          sync_ok <= 1'b1;
          state <= OUTW;
        end
        OUTW: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= sync_ok;
            m_axis_tdata <= {sync_ok ? VW'(lane_res) : VW'(0), t_req};
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[239:48] == '0))
    else $error("failed result carries data");
`endif
endmodule

[tb/vtsi_checker.sv]
// Checker: watches the request and result streams, predicts results and compares them.
`timescale 1ns / 100ps
module vtsi_checker import vtsi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [239:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [239:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           fail_count,
  output int           pending
);
  localparam int DEPTH = 16;
  localparam int FRAC = 16;
  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic         ok;
    logic [239:0] data;
  } sync_result_t;

  logic [TIME_W-1:0] sample_time [DEPTH];
  vel_vec_t          sample_vel [DEPTH];
  int unsigned       head, count;
  logic [GAP_W-1:0]  gap_limit;
  sync_result_t      exp_fifo [EXP_DEPTH];
  int unsigned       exp_wr, exp_rd;

  assign pending = int'(exp_wr - exp_rd);

  function automatic int unsigned idx(int unsigned k);
    return (head + k) % DEPTH;
  endfunction

  function automatic sync_result_t sync_predict(logic [TIME_W-1:0] t);
    sync_result_t r;
    int unsigned a, b;
    logic [TIME_W-1:0] d0, d1, span;
    logic [63:0] w;
    logic signed [80:0] acc;
    r.ok = 1'b0;
    r.data = '0;
    r.data[TIME_W-1:0] = t;
    while (count >= 2) begin
      if (sample_time[idx(0)] > t) return r;
      if (sample_time[idx(1)] < t) begin
        head = idx(1);
        count--;
      end else break;
    end
    if (count < 2) return r;
    a = idx(0);
    b = idx(1);
    d0 = t - sample_time[a];
    d1 = sample_time[b] - t;
    if (d0 > gap_limit || d1 > gap_limit) return r;
    span = sample_time[b] - sample_time[a];
    w = 0;
    if (span != 0) w = ({16'd0, d0} << FRAC) / span;
    if (w > (64'd1 << FRAC)) w = 64'd1 << FRAC;
    for (int j = 0; j < LANES; j++) begin
      acc = 81'($signed(sample_vel[a][j])) * $signed({1'b0, 64'(65536 - w)})
          + 81'($signed(sample_vel[b][j])) * $signed({1'b0, w}) + 81'sd32768;
      acc = acc >>> FRAC;
      r.data[TIME_W + VEL_W*j +: VEL_W] = acc[VEL_W-1:0];
    end
    r.ok = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    sync_result_t exp_r;
    if (rst) begin
      head = 0;
      count = 0;
      gap_limit <= GAP_RESET;
      fail_count <= 0;
      exp_wr = 0;
      exp_rd = 0;
    end else begin
      if (psel && penable && pwrite && paddr[1:0] == {REG_MAX_GAP, 1'b0})
        gap_limit <= pwdata[GAP_W-1:0];
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == FUNC_PUSH) begin
          if (count >= DEPTH) begin
            head = idx(1);
            count--;
          end
          sample_time[idx(count)] = s_axis_tdata[TIME_W-1:0];
          for (int j = 0; j < LANES; j++)
            sample_vel[idx(count)][j] = s_axis_tdata[TIME_W + VEL_W*j +: VEL_W];
          count++;
        end else begin
          exp_fifo[exp_wr % EXP_DEPTH] = sync_predict(s_axis_tdata[TIME_W-1:0]);
          exp_wr++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_wr == exp_rd) begin
          $display("%0t: unexpected result ok=%b data=%h", $time, m_axis_tuser,
                   m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = exp_fifo[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (exp_r.ok !== m_axis_tuser || exp_r.data !== m_axis_tdata) begin
            $display("%0t: mismatch expected ok=%b data=%h", $time, exp_r.ok, exp_r.data);
            $display("%0t:          actual   ok=%b data=%h", $time, m_axis_tuser,
                     m_axis_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[tb/tb_velocity_timestamp_sync_interpolator.sv]
// Testbench top: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 100ps
module tb_velocity_timestamp_sync_interpolator import vtsi_pkg::*; ();
  logic         clk = 0, rst = 1;
  logic         s_axis_tvalid = 0, s_axis_tready, s_axis_tuser = 0;
  logic [239:0] s_axis_tdata = '0;
  logic         m_axis_tvalid, m_axis_tready = 0, m_axis_tuser;
  logic [239:0] m_axis_tdata;
  logic         psel = 0, penable = 0, pwrite = 0, pready;
  logic [1:0]   paddr = 0;
  logic [31:0]  pwdata = 0, prdata;
  int           fail_count, pending;
  int           cycles = 0;
  int           stall_left = 0;
  bit           sink_on = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  velocity_timestamp_sync_interpolator u_dut (.*);

  vtsi_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3);
    return $urandom_range(150, 20);
  endfunction

  always @(negedge clk) begin
    if (!sink_on) m_axis_tready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(99) == 0) begin
      stall_left <= $urandom_range(150, 20);
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= ($urandom_range(9) < 7);
  end

  task automatic send(logic func, logic [47:0] t, logic [191:0] vel);
    repeat (gap_len()) @(negedge clk);
    s_axis_tvalid = 1;
    s_axis_tuser = func;
    s_axis_tdata = {vel, t};
    while (!s_axis_tready) @(negedge clk);
    @(negedge clk);
    s_axis_tvalid = 0;
  endtask

  function automatic logic [191:0] rand_vel();
    logic [191:0] v;
    for (int j = 0; j < 6; j++)
      case ($urandom_range(5))
        0: v[32*j +: 32] = 32'h8000_0000;
        1: v[32*j +: 32] = 32'h7fff_ffff;
        default: v[32*j +: 32] = $urandom;
      endcase
    return v;
  endfunction

  task automatic write_gap(logic [23:0] g);
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= {REG_MAX_GAP, 1'b0}; pwdata <= {8'($urandom), g};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic push_at(logic [47:0] t);
    send(FUNC_PUSH, t, rand_vel());
  endtask

  task automatic sync_at(logic [47:0] t);
    send(FUNC_SYNC, t, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
  endtask

  initial begin
    logic [47:0] t;
    repeat (8) @(negedge clk);
    rst <= 0;
    sink_on = 1;
    // directed
    sync_at(48'd0);                              // empty queue
    push_at(48'd1000);
    sync_at(48'd1000);                           // one sample
    sync_at(48'd900);                            // oldest later than request
    push_at(48'd1000);
    sync_at(48'd1000);                           // equal neighbour times
    push_at(48'd2000);
    sync_at(48'd1500);
    sync_at(48'd2000);
    push_at(48'd500000);
    sync_at(48'd400000);                         // gap exceeded
    push_at(48'hffff_ffff_fffe);
    push_at(48'hffff_ffff_ffff);
    sync_at(48'hffff_ffff_ffff);
    sync_at(48'hffff_ffff_ffff);
    push_at(48'h0);                              // out of order
    push_at(48'h10);
    sync_at(48'h8);
    for (int i = 0; i < 18; i++) push_at(48'h100 + i * 16); // overflow queue
    write_gap(24'hffffff);
    sync_at(48'h0);
    sync_at(48'h1f8);
    write_gap(24'd0);
    sync_at(48'h200);
    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_gap(24'd0);
        1: write_gap(24'hffffff);
        2: write_gap(24'd50);
        default: write_gap(24'($urandom_range(400, 1)));
      endcase
      t = 48'($urandom_range(1000));
      if (ph == 5) t = 48'hffff_ffff_0000;
      for (int i = 0; i < 230; i++) begin
        if ($urandom_range(9) < 6) begin
          if ($urandom_range(19) == 0) t = 48'({$urandom, $urandom});
          else if ($urandom_range(9) == 0) t = t - $urandom_range(20);
          else t = t + $urandom_range(60);
          push_at(t);
        end else begin
          sync_at(($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                          : t - $urandom_range(120) + $urandom_range(30));
        end
      end
    end
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

[filelist.f]
design/vtsi_pkg.sv
design/vtsi_ram.sv
design/vtsi_div.sv
design/vtsi_lane.sv
design/velocity_timestamp_sync_interpolator.sv
tb/vtsi_checker.sv
tb/tb_velocity_timestamp_sync_interpolator.sv
